// ----- hdl/lpht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared sizes, codes and item types of the linear-probing hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

    // table geometry; SLOTS is a power of two so the home slot is a mask
    localparam int SLOTS      = 256;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int HASH_BITS  = 32;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int COUNT_W = $clog2(SLOTS + 1);

    // port field widths
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 8;
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 9;

    // operations
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // slot flags
    localparam logic [1:0] FLAG_EMPTY   = 2'd0;
    localparam logic [1:0] FLAG_DELETED = 2'd1;
    localparam logic [1:0] FLAG_USED    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] key_hash;
        logic [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    slot_index;
        logic [DATA_W-1:0]   stored_value;
        logic [OCC_W-1:0]    occupancy;
    } t_rsp;

    typedef struct packed {
        logic [1:0]            flag;
        logic [HASH_BITS-1:0]  hash;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ----- hdl/lpht_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hdl/linear_probe_hash_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing hash table with linear probing and deleted-slot markers.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------
//   request | in        | i_in_valid / o_in_ready  | i_in  (t_req)
//   result  | out       | o_out_valid / i_out_ready| o_out (t_rsp)
//
// Probing: an item probes P slots (1..SLOTS), and the entry RAM gives one slot
//   per cycle. A full-table insert or an unknown operation skips the probe run
//   and goes straight to the result. The home slot is the low SLOT_W bits
//   of the hash, since the slot count is a power of two.
// Reset: after reset a clearing pass marks every slot empty;
//   no item is taken during it.
// Stalls: the result sits in an output register; a finished item waits in a
//   hold stage while the previous result is still not taken.
//
// Every slot lives in one RAM word {flag, hash, key, value}. The probe loop
// reads slot s and, in the same cycle as it checks slot s, already addresses
// slot s+1. The single write of an item (insert or delete mark) happens at
// the end of its probe run, so reads and writes of one item never overlap on
// the same entry.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit
    import lpht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(SLOTS);

    logic [2:0]         r_state, n_state;
    t_req               r_req,   n_req;
    logic [SLOT_W-1:0]  r_slot,  n_slot;
    logic [SLOT_W-1:0]  r_probe, n_probe;
    logic [SLOT_W-1:0]  r_clr,   n_clr;
    logic [COUNT_W-1:0] r_count, n_count;
    t_rsp               r_res,   n_res;
    t_rsp               r_out,   n_out;
    logic               r_out_valid, n_out_valid;

    // entry RAM ports
    logic              w_we;
    logic [SLOT_W-1:0] w_waddr;
    t_entry            w_wdata;
    logic [SLOT_W-1:0] w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    t_entry            w_entry;

    // probe helpers
    logic              w_in_acc;
    logic              w_match;
    logic              w_last;
    logic [SLOT_W-1:0] w_slot_next;

    lpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_entry     = t_entry'(w_rdata);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_match     = (w_entry.hash == r_req.key_hash[HASH_BITS-1:0]) &&
                         (w_entry.key  == r_req.key[KEY_BITS-1:0]);
    assign w_last      = (r_probe == LAST_SLOT);
    assign w_slot_next = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_slot      = r_slot;
        n_probe     = r_probe;
        n_clr       = r_clr;
        n_count     = r_count;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_we        = 1'b0;
        w_waddr     = r_slot;
        w_wdata     = w_entry;
        w_raddr     = r_slot;

        case (r_state)
            S_CLEAR: begin
                // sweep every slot to empty, one per cycle
                w_we         = 1'b1;
                w_waddr      = r_clr;
                w_wdata      = '0;
                w_wdata.flag = FLAG_EMPTY;
                n_clr        = r_clr + 1'b1;
                if (r_clr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                // address the home slot now so its data arrives with S_CHECK
                w_raddr = i_in.key_hash[SLOT_W-1:0];
                if (w_in_acc) begin
                    n_req   = i_in;
                    n_probe = '0;
                    n_slot  = i_in.key_hash[SLOT_W-1:0];
                    n_res   = '0;
                    n_res.occupancy = OCC_W'(r_count);
                    if (i_in.operation == OP_INSERT && r_count >= FULL_CNT) begin
                        n_res.status = ST_FULL;
                        n_state      = S_DONE;
                    end else if (i_in.operation == OP_INSERT ||
                                 i_in.operation == OP_FIND ||
                                 i_in.operation == OP_REMOVE) begin
                        n_state = S_CHECK;
                    end else begin
                        n_res.status = ST_NOT_FOUND;
                        n_state      = S_DONE;
                    end
                end
            end

            S_CHECK: begin
                // address the next slot ahead of the decision
                w_raddr = w_slot_next;
                n_slot  = w_slot_next;
                n_probe = r_probe + 1'b1;
                n_res   = '0;
                if (r_req.operation == OP_INSERT) begin
                    if (w_entry.flag != FLAG_USED) begin
                        // claim an empty or deleted slot
                        w_we          = 1'b1;
                        w_waddr       = r_slot;
                        w_wdata.flag  = FLAG_USED;
                        w_wdata.hash  = r_req.key_hash[HASH_BITS-1:0];
                        w_wdata.key   = r_req.key[KEY_BITS-1:0];
                        w_wdata.value = r_req.value[VALUE_BITS-1:0];
                        n_count          = r_count + 1'b1;
                        n_res.status     = ST_OK;
                        n_res.slot_index = IDX_W'(r_slot);
                        n_state          = S_DONE;
                    end else if (w_match) begin
                        n_res.status = ST_PRESENT;
                        n_state      = S_DONE;
                    end else if (w_last) begin
                        n_res.status = ST_FULL;
                        n_state      = S_DONE;
                    end
                end else begin
                    if (w_entry.flag == FLAG_EMPTY) begin
                        n_res.status = ST_NOT_FOUND;
                        n_state      = S_DONE;
                    end else if (w_match) begin
                        if (w_entry.flag == FLAG_USED) begin
                            n_res.status       = ST_OK;
                            n_res.slot_index   = IDX_W'(r_slot);
                            n_res.stored_value = DATA_W'(w_entry.value);
                            if (r_req.operation == OP_REMOVE) begin
                                // mark deleted, keep hash, key and value
                                w_we         = 1'b1;
                                w_waddr      = r_slot;
                                w_wdata.flag = FLAG_DELETED;
                                n_count      = r_count - 1'b1;
                            end
                        end else begin
                            n_res.status = ST_NOT_FOUND;
                        end
                        n_state = S_DONE;
                    end else if (w_last) begin
                        n_res.status = ST_NOT_FOUND;
                        n_state      = S_DONE;
                    end
                end
                n_res.occupancy = OCC_W'(n_count);
            end

            S_DONE: begin
                // hand over once the output register is free or being taken
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_slot  <= n_slot;
        r_probe <= n_probe;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- hdl/lpht_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the hash table unit, bound to the top level.
// ----------------------------------------------------------------------------
module lpht_checker
    import lpht_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_req i_in,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_rsp o_out
);

    // a result offered but not taken holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // reset starts the clearing pass: no item taken, no result shown
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("unit active right after reset");

    // a failed request reports no slot and no value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_OK |->
            o_out.slot_index == '0 && o_out.stored_value == '0)
        else $error("failed request carries slot or value");

    // occupancy never exceeds the slot count
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out.occupancy) <= 32'(SLOTS))
        else $error("occupancy above slot count");

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
